### rtl/ltsc_pkg.sv
`default_nettype none

package ltsc_pkg;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_APPEND     = 3'd1,
    OP_COMMIT     = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_SCROLL_OUT = 3'd4
  } op_t;

  typedef enum logic {
    CFG_STEP_WAIT = 1'b0,
    CFG_TURN_WAIT = 1'b1
  } cfg_reg_t;

  localparam int VisibleColumns = 96;
  localparam int TextCapacity   = 256;

  localparam logic [7:0] StepWaitReset = 8'd4;
  localparam logic [7:0] TurnWaitReset = 8'd100;
  localparam logic [8:0] NoZero        = 9'd256;
  localparam logic [3:0] FadeLast      = 4'd7;

endpackage

`default_nettype wire

### rtl/led_text_scroll_controller.sv
// led text scroll controller
// item channel: item_valid / item_stall carry one command beat (operation,
// char_code): frame tick, append character, commit, clear, start scroll-out.
// result channel: result_valid / result_stall carry one beat per item with
// the scroll position, fade offset, mode, direction and committed length,
// all taken after that item's update.
// an item accepted at a clock edge shows its result from the next cycle on. one item
// per cycle is taken while no result waits under result_stall; the state registers are
// updated by a single level of logic and double as the result register.
// a result waiting under result_stall holds the item side stalled; when the
// result is taken in the same cycle a new item is accepted.
// cfg_write with cfg_index writes step_wait (0) or turn_wait (1); the user must
// write them only while idle, which the block itself does not enforce.
// rst (synchronous, active high) clears the text, the position, counters,
// direction and mode, reloads step_wait 4 and turn_wait 100, and drops
// result_valid. item_stall is high while rst is high.
`default_nettype none

module led_text_scroll_controller
  import ltsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output      logic        item_stall,
  input  wire logic [2:0]  operation,
  input  wire logic [7:0]  char_code,
  output      logic        result_valid,
  input  wire logic        result_stall,
  output      logic [10:0] scroll_position,
  output      logic [3:0]  fade_offset,
  output      logic        display_mode,
  output      logic        direction,
  output      logic [10:0] line_length_px,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [7:0]  step_wait;
  logic [7:0]  turn_wait;

  logic [7:0]  pending_count, pending_count_next;
  logic [8:0]  first_zero_index, first_zero_index_next;
  logic [10:0] committed_length_px, committed_length_px_next;
  logic [10:0] position_px, position_px_next;
  logic [7:0]  step_wait_count, step_wait_count_next;
  logic [7:0]  turn_delay_count, turn_delay_count_next;
  logic        reverse_flag, reverse_flag_next;
  logic [3:0]  fade_count, fade_count_next;
  logic        scrollout_flag, scrollout_flag_next;

  logic        accept;
  logic        step_due;
  logic        turn_done;
  logic        before_end;
  logic [8:0]  pending_ext;
  logic [7:0]  commit_len;
  logic [10:0] commit_px;
  logic [7:0]  step_count_stepped;
  logic [7:0]  turn_count_stepped;
  logic [3:0]  fade_stepped;

  assign item_stall = rst | (result_valid & result_stall);
  assign accept     = item_valid & ~item_stall;

  assign pending_ext = {1'b0, pending_count};

  // counter must exceed the signed wait before a step is due
  assign step_due = $signed({1'b0, step_wait_count}) > $signed({step_wait[7], step_wait});
  assign step_count_stepped = step_due ? 8'd0 : step_wait_count + 8'd1;

  assign turn_done = ~(turn_delay_count < turn_wait);
  assign turn_count_stepped = turn_done ? 8'd0 : turn_delay_count + 8'd1;

  // line end not yet at the last visible column
  assign before_end = ({2'b00, position_px} + 13'(VisibleColumns))
                      < {2'b00, committed_length_px};

  // length up to the first zero character, six pixels each
  assign commit_len = (first_zero_index < pending_ext) ? first_zero_index[7:0]
                                                       : pending_count;
  assign commit_px  = {1'b0, commit_len, 2'b00} + {2'b00, commit_len, 1'b0};

  assign fade_stepped = step_due ? fade_count + 4'd1 : fade_count;

  always_comb begin
    pending_count_next       = pending_count;
    first_zero_index_next    = first_zero_index;
    committed_length_px_next = committed_length_px;
    position_px_next         = position_px;
    step_wait_count_next     = step_wait_count;
    turn_delay_count_next    = turn_delay_count;
    reverse_flag_next        = reverse_flag;
    fade_count_next          = fade_count;
    scrollout_flag_next      = scrollout_flag;
    unique case (op_t'(operation))
      OP_TICK: begin
        if (!scrollout_flag) begin
          if (!reverse_flag) begin
            if (before_end) begin
              step_wait_count_next = step_count_stepped;
              if (step_due) begin
                position_px_next = position_px + 11'd1;
              end
            end else begin
              turn_delay_count_next = turn_count_stepped;
              if (turn_done) begin
                reverse_flag_next = 1'b1;
              end
            end
          end else begin
            if (position_px != 11'd0) begin
              position_px_next = (position_px > 11'd2) ? position_px - 11'd2 : 11'd0;
            end else begin
              turn_delay_count_next = turn_count_stepped;
              if (turn_done) begin
                reverse_flag_next = 1'b0;
              end
            end
          end
        end else begin
          step_wait_count_next = step_count_stepped;
          fade_count_next      = fade_stepped;
          // fade finished: empty text, commit an empty line
          if (fade_stepped > FadeLast) begin
            pending_count_next       = 8'd0;
            first_zero_index_next    = NoZero;
            position_px_next         = 11'd0;
            committed_length_px_next = 11'd0;
            scrollout_flag_next      = 1'b0;
          end
        end
      end
      OP_APPEND: begin
        if ((pending_ext + 9'd1) < 9'(TextCapacity)) begin
          if ((char_code == 8'd0) && (pending_ext < first_zero_index)) begin
            first_zero_index_next = pending_ext;
          end
          pending_count_next = pending_count + 8'd1;
        end
      end
      OP_COMMIT: begin
        committed_length_px_next = commit_px;
        position_px_next         = 11'd0;
        scrollout_flag_next      = 1'b0;
      end
      OP_CLEAR: begin
        pending_count_next    = 8'd0;
        first_zero_index_next = NoZero;
        position_px_next      = 11'd0;
      end
      OP_SCROLL_OUT: begin
        scrollout_flag_next = 1'b1;
        fade_count_next     = 4'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_wait           <= StepWaitReset;
      turn_wait           <= TurnWaitReset;
      pending_count       <= 8'd0;
      first_zero_index    <= NoZero;
      committed_length_px <= 11'd0;
      position_px         <= 11'd0;
      step_wait_count     <= 8'd0;
      turn_delay_count    <= 8'd0;
      reverse_flag        <= 1'b0;
      fade_count          <= 4'd0;
      scrollout_flag      <= 1'b0;
      result_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_STEP_WAIT: step_wait <= cfg_data;
          CFG_TURN_WAIT: turn_wait <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        pending_count       <= pending_count_next;
        first_zero_index    <= first_zero_index_next;
        committed_length_px <= committed_length_px_next;
        position_px         <= position_px_next;
        step_wait_count     <= step_wait_count_next;
        turn_delay_count    <= turn_delay_count_next;
        reverse_flag        <= reverse_flag_next;
        fade_count          <= fade_count_next;
        scrollout_flag      <= scrollout_flag_next;
        result_valid        <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // state only moves on an accepted beat, so it holds while a result waits
  assign scroll_position = position_px;
  assign fade_offset     = fade_count;
  assign display_mode    = scrollout_flag;
  assign direction       = reverse_flag;
  assign line_length_px  = committed_length_px;

endmodule

`default_nettype wire

### rtl/ltsc_checker.sv
`default_nettype none

module ltsc_checker
  import ltsc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_stall,
  input wire logic [2:0]  operation,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [10:0] scroll_position,
  input wire logic [3:0]  fade_offset,
  input wire logic        display_mode
);

  logic item_beat;

  assign item_beat = item_valid & ~item_stall;

  // every accepted beat yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    item_beat |=> result_valid)
    else $error("no result after accepted item");

  a_clear_homes: assert property (@(posedge clk) disable iff (rst)
    (item_beat && operation == OP_CLEAR) |=> scroll_position == 11'd0)
    else $error("clear did not reset position");

  a_commit_mode: assert property (@(posedge clk) disable iff (rst)
    (item_beat && operation == OP_COMMIT)
      |=> (scroll_position == 11'd0 && display_mode == 1'b0))
    else $error("commit did not restart scrolling");

  a_scroll_out_start: assert property (@(posedge clk) disable iff (rst)
    (item_beat && operation == OP_SCROLL_OUT)
      |=> (display_mode == 1'b1 && fade_offset == 4'd0))
    else $error("scroll-out did not start");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(scroll_position)))
    else $error("stalled result changed");

endmodule

bind led_text_scroll_controller ltsc_checker u_ltsc_checker (
  .clk             (clk),
  .rst             (rst),
  .item_valid      (item_valid),
  .item_stall      (item_stall),
  .operation       (operation),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .scroll_position (scroll_position),
  .fade_offset     (fade_offset),
  .display_mode    (display_mode)
);

`default_nettype wire
